// ----- rtl/core/qcs_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// qcs_pkg: shared types and constants of the quadratic contour segmenter
// Holds the point and segment beat formats and the size of the store that
// keeps the control points ahead of the first on-curve point.
// ----------------------------------------------------------------------------
package qcs_pkg;

    localparam int LEAD_DEPTH = 16;
    localparam int LEAD_AW    = (LEAD_DEPTH > 1) ? $clog2(LEAD_DEPTH) : 1;
    localparam int LEAD_CW    = $clog2(LEAD_DEPTH + 1);

    localparam logic KIND_LINE = 1'b0;
    localparam logic KIND_QUAD = 1'b1;

    typedef struct packed {
        logic signed [15:0] point_x;
        logic signed [15:0] point_y;
        logic               on_pt;
        logic               last_point;
    } point_t;

    typedef struct packed {
        logic               kind;
        logic signed [15:0] start_x;
        logic signed [15:0] start_y;
        logic signed [15:0] ctrl_x;
        logic signed [15:0] ctrl_y;
        logic signed [15:0] end_x;
        logic signed [15:0] end_y;
        logic               last_of_run;
        logic               overflow;
    } seg_t;

    typedef struct packed {
        logic load_in;
        logic step_point;
        logic step_lead;
        logic step_close;
    } qcs_cmd_t;

    typedef struct packed {
        logic out_free;
        logic in_last;
        logic close_due;
        logic lead_zero;
        logic idx_end;
    } qcs_stat_t;

endpackage
`default_nettype wire

// ----- rtl/core/qcs_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// qcs_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module qcs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ----- rtl/core/qcs_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// qcs_ctrl: sequencer of the quadratic contour segmenter
// Steps the datapath through the point, the lead replay and the closing
// segment, one segment beat at a time.
// ----------------------------------------------------------------------------
module qcs_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               point_valid,
    output logic                    point_ready,
    input  wire qcs_pkg::qcs_stat_t stat,
    output qcs_pkg::qcs_cmd_t       cmd
);
    import qcs_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_POINT,
        S_READ,
        S_LEAD,
        S_CLOSE
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        point_ready = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                point_ready = 1'b1;
                cmd.load_in = point_valid;
                if (point_valid)
                begin
                    state_next = S_POINT;
                end
            end
            S_POINT:
            begin
                if (stat.out_free)
                begin
                    cmd.step_point = 1'b1;
                    if (stat.in_last && stat.close_due)
                    begin
                        state_next = stat.lead_zero ? S_CLOSE : S_READ;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_READ:
            begin
                state_next = S_LEAD;
            end
            S_LEAD:
            begin
                if (stat.out_free)
                begin
                    cmd.step_lead = 1'b1;
                    state_next    = stat.idx_end ? S_CLOSE : S_READ;
                end
            end
            S_CLOSE:
            begin
                if (stat.out_free)
                begin
                    cmd.step_close = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/core/qcs_dp.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// qcs_dp: datapath of the quadratic contour segmenter
// Holds the contour state, the lead control store and the segment output
// register, and forms at most one segment per step command.
// ----------------------------------------------------------------------------
module qcs_dp (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire qcs_pkg::point_t   point,
    output logic                   seg_valid,
    input  wire logic              seg_ready,
    output qcs_pkg::seg_t          seg,
    input  wire qcs_pkg::qcs_cmd_t cmd,
    output qcs_pkg::qcs_stat_t     stat
);
    import qcs_pkg::*;

    point_t              in_reg;
    logic                seen_reg, seen_next;
    logic                pend_valid_reg, pend_valid_next;
    logic [LEAD_CW-1:0]  lead_count_reg, lead_count_next;
    logic                lead_ovf_reg, lead_ovf_next;
    logic [LEAD_AW-1:0]  idx_reg, idx_next;
    logic                out_valid_reg, out_valid_next;
    seg_t                out_reg, out_next;
    logic signed [15:0]  first_x_reg, first_x_next, first_y_reg, first_y_next;
    logic signed [15:0]  start_x_reg, start_x_next, start_y_reg, start_y_next;
    logic signed [15:0]  pend_x_reg, pend_x_next, pend_y_reg, pend_y_next;

    logic                lead_we;
    logic [31:0]         lead_rdata;
    logic                out_free;

    logic signed [15:0]  tp_x, tp_y;
    logic                tp_on;
    logic signed [16:0]  sum_x, sum_y;
    logic signed [15:0]  mid_x, mid_y;
    logic                tp_emit;
    seg_t                tp_seg;
    logic signed [15:0]  tp_start_x, tp_start_y;
    logic                tp_pend_valid;
    logic signed [15:0]  tp_pend_x, tp_pend_y;

    qcs_ram #(
        .WIDTH (32),
        .DEPTH (LEAD_DEPTH)
    ) u_lead_ram (
        .clk   (clk),
        .we    (lead_we),
        .waddr (lead_count_reg[LEAD_AW-1:0]),
        .wdata ({in_reg.point_x, in_reg.point_y}),
        .raddr (idx_reg),
        .rdata (lead_rdata)
    );

    assign out_free  = !out_valid_reg || seg_ready;
    assign seg_valid = out_valid_reg;
    assign seg       = out_reg;

    always_comb
    begin
        stat.out_free  = out_free;
        stat.in_last   = in_reg.last_point;
        stat.close_due = seen_reg || in_reg.on_pt;
        stat.lead_zero = (lead_count_reg == '0);
        stat.idx_end   = ((LEAD_CW'(idx_reg) + LEAD_CW'(1)) == lead_count_reg);
    end

    always_comb
    begin
        if (cmd.step_lead)
        begin
            tp_x  = signed'(lead_rdata[31:16]);
            tp_y  = signed'(lead_rdata[15:0]);
            tp_on = 1'b0;
        end
        else if (cmd.step_close)
        begin
            tp_x  = first_x_reg;
            tp_y  = first_y_reg;
            tp_on = 1'b1;
        end
        else
        begin
            tp_x  = in_reg.point_x;
            tp_y  = in_reg.point_y;
            tp_on = in_reg.on_pt;
        end
    end

    assign sum_x = 17'(pend_x_reg) + 17'(tp_x);
    assign sum_y = 17'(pend_y_reg) + 17'(tp_y);
    assign mid_x = sum_x[16:1];
    assign mid_y = sum_y[16:1];

    always_comb
    begin
        tp_seg             = '0;
        tp_seg.start_x     = start_x_reg;
        tp_seg.start_y     = start_y_reg;
        tp_seg.overflow    = lead_ovf_reg;
        tp_pend_x          = pend_x_reg;
        tp_pend_y          = pend_y_reg;
        if (tp_on)
        begin
            tp_emit       = 1'b1;
            tp_seg.kind   = pend_valid_reg ? KIND_QUAD : KIND_LINE;
            tp_seg.ctrl_x = pend_valid_reg ? pend_x_reg : 16'sd0;
            tp_seg.ctrl_y = pend_valid_reg ? pend_y_reg : 16'sd0;
            tp_seg.end_x  = tp_x;
            tp_seg.end_y  = tp_y;
            tp_start_x    = tp_x;
            tp_start_y    = tp_y;
            tp_pend_valid = 1'b0;
        end
        else
        begin
            tp_emit       = pend_valid_reg;
            tp_seg.kind   = KIND_QUAD;
            tp_seg.ctrl_x = pend_x_reg;
            tp_seg.ctrl_y = pend_y_reg;
            tp_seg.end_x  = mid_x;
            tp_seg.end_y  = mid_y;
            tp_start_x    = pend_valid_reg ? mid_x : start_x_reg;
            tp_start_y    = pend_valid_reg ? mid_y : start_y_reg;
            tp_pend_valid = 1'b1;
            tp_pend_x     = tp_x;
            tp_pend_y     = tp_y;
        end
    end

    always_comb
    begin
        seen_next       = seen_reg;
        pend_valid_next = pend_valid_reg;
        lead_count_next = lead_count_reg;
        lead_ovf_next   = lead_ovf_reg;
        idx_next        = idx_reg;
        first_x_next    = first_x_reg;
        first_y_next    = first_y_reg;
        start_x_next    = start_x_reg;
        start_y_next    = start_y_reg;
        pend_x_next     = pend_x_reg;
        pend_y_next     = pend_y_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg && !seg_ready;
        lead_we         = 1'b0;

        if (cmd.step_point || cmd.step_lead || cmd.step_close)
        begin
            if (seen_reg || !cmd.step_point)
            begin
                pend_valid_next = tp_pend_valid;
                start_x_next    = tp_start_x;
                start_y_next    = tp_start_y;
                pend_x_next     = tp_pend_x;
                pend_y_next     = tp_pend_y;
                if (tp_emit)
                begin
                    out_valid_next          = 1'b1;
                    out_next                = tp_seg;
                    out_next.last_of_run    = cmd.step_close ||
                                              (cmd.step_point && !in_reg.last_point);
                end
            end
        end

        if (cmd.step_point)
        begin
            if (!seen_reg)
            begin
                if (in_reg.on_pt)
                begin
                    seen_next       = 1'b1;
                    first_x_next    = in_reg.point_x;
                    first_y_next    = in_reg.point_y;
                    start_x_next    = in_reg.point_x;
                    start_y_next    = in_reg.point_y;
                    pend_valid_next = 1'b0;
                end
                else if (lead_count_reg < LEAD_CW'(LEAD_DEPTH))
                begin
                    lead_we         = 1'b1;
                    lead_count_next = lead_count_reg + LEAD_CW'(1);
                end
                else
                begin
                    lead_ovf_next = 1'b1;
                end
            end
            if (in_reg.last_point && !(seen_reg || in_reg.on_pt))
            begin
                seen_next       = 1'b0;
                pend_valid_next = 1'b0;
                lead_count_next = '0;
                lead_ovf_next   = 1'b0;
            end
        end

        if (cmd.step_lead)
        begin
            idx_next = idx_reg + LEAD_AW'(1);
        end

        if (cmd.step_close)
        begin
            seen_next       = 1'b0;
            pend_valid_next = 1'b0;
            lead_count_next = '0;
            lead_ovf_next   = 1'b0;
            idx_next        = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg       <= 1'b0;
            pend_valid_reg <= 1'b0;
            lead_count_reg <= '0;
            lead_ovf_reg   <= 1'b0;
            idx_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            seen_reg       <= seen_next;
            pend_valid_reg <= pend_valid_next;
            lead_count_reg <= lead_count_next;
            lead_ovf_reg   <= lead_ovf_next;
            idx_reg        <= idx_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            in_reg <= point;
        end
        first_x_reg <= first_x_next;
        first_y_reg <= first_y_next;
        start_x_reg <= start_x_next;
        start_y_reg <= start_y_next;
        pend_x_reg  <= pend_x_next;
        pend_y_reg  <= pend_y_next;
        out_reg     <= out_next;
    end

endmodule
`default_nettype wire

// ----- rtl/core/quadratic_contour_segmenter_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// quadratic_contour_segmenter_unit: outline contour to segment converter
// Flow: a point beat is taken into the input register; its segment, if any,
// is written to the output register once that register is free. A new point
// is taken only when the last is through; a closing point also replays each
// stored leading control point (one lead RAM read, one step), then closes.
// Reset: rst_n clears the contour state; the lead RAM needs no clearing.
// ----------------------------------------------------------------------------
module quadratic_contour_segmenter_unit (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            point_valid,
    output logic                 point_ready,
    input  wire qcs_pkg::point_t point,
    output logic                 seg_valid,
    input  wire logic            seg_ready,
    output qcs_pkg::seg_t        seg
);
    import qcs_pkg::*;

    qcs_cmd_t  cmd;
    qcs_stat_t stat;

    qcs_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .point_valid (point_valid),
        .point_ready (point_ready),
        .stat        (stat),
        .cmd         (cmd)
    );

    qcs_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .point     (point),
        .seg_valid (seg_valid),
        .seg_ready (seg_ready),
        .seg       (seg),
        .cmd       (cmd),
        .stat      (stat)
    );

    a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load_in, cmd.step_point, cmd.step_lead, cmd.step_close}))
        else $error("conflicting datapath commands");

    a_busy_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (point_valid && point_ready) |=> !point_ready)
        else $error("point taken while previous point still in work");

    a_step_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.step_point || cmd.step_lead || cmd.step_close) |-> stat.out_free)
        else $error("segment step with output register occupied");

    a_close_last: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step_close |=> (seg_valid && seg.last_of_run))
        else $error("closing segment not marked last of run");

endmodule
`default_nettype wire
